>>> design/kfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfc_pkg
// shared types, codes and constants for the keypad calculator
// ----------------------------------------------------------------------------
package kfc_pkg;

    localparam int OPND_W  = 7;
    localparam int VALUE_W = 14;
    localparam int STEP_W  = 4;
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(VALUE_W);

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_EQUAL = 8'h3D;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] CMD_CURSOR  = 8'hC0;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [OPND_W-1:0] RADIX = OPND_W'(10);

    localparam logic [1:0] KIND_DIGIT  = 2'd0;
    localparam logic [1:0] KIND_OPER   = 2'd1;
    localparam logic [1:0] KIND_EQUALS = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    typedef struct packed {
        logic                start;
        logic [VALUE_W-1:0]  dividend;
        logic [OPND_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [VALUE_W-1:0]  quotient;
        logic [OPND_W-1:0]   remainder;
    } div_rsp_t;

    function automatic logic [7:0] op_glyph(input logic [1:0] code);
        logic [7:0] g;
        case (code)
            2'd0:    g = 8'h2B;
            2'd1:    g = 8'h2D;
            2'd2:    g = 8'h78;
            default: g = 8'h2F;
        endcase
        return g;
    endfunction

endpackage

>>> design/kfc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfc_divider
// restoring divider, one quotient bit per cycle, shared by divide and
// decimal conversion
// ----------------------------------------------------------------------------
module kfc_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  kfc_pkg::div_req_t req,
    output kfc_pkg::div_rsp_t rsp
);
    import kfc_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0]  quo_reg, quo_next;
    logic [OPND_W-1:0]   rem_reg, rem_next;
    logic [OPND_W-1:0]   dvs_reg, dvs_next;
    logic [OPND_W:0]     rem_shift;
    logic [OPND_W:0]     rem_diff;
    logic                fits;

    assign rem_shift = {rem_reg, quo_reg[VALUE_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_STEPS;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_W-2:0], fits};
            rem_next = fits ? rem_diff[OPND_W-1:0] : rem_shift[OPND_W-1:0];
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> design/keypad_four_function_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_four_function_calculator
// key events in, display bytes out; two-digit operands, four operations
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one key event per beat: kind
// and key_value. Output channel (out_valid/out_ready) carries display beats:
// display_byte, is_command, is_error, and last on the final beat of a key.
// One key is handled at a time; in_ready is high only while idle with no
// output pending. A key that produces nothing leaves the block idle.
// Digit, operator and clear keys give at most one beat, visible the cycle
// after acceptance. Equals gives cursor command, '=', optional '-', then one
// to four digits, or a clear error beat in place of the result on division
// by zero. The result is formed by a sequencer around one restoring divider
// (14 quotient steps per pass): divide takes one pass, and the decimal
// conversion one pass per digit. Each output beat waits in the output
// register until taken, so a stalled receiver simply holds the sequencer.
// Reset clears operands, operator and flags and leaves the block idle with
// no output pending.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [3:0] key_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] display_byte,
    output logic       is_command,
    output logic       is_error,
    output logic       last
);
    import kfc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_OUT, S_EQ, S_DZ, S_COMPUTE, S_DIVW,
        S_SIGN, S_CONV, S_CONVW, S_DIGIT
    } state_t;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic                ov_reg, ov_next;
    logic [7:0]          byte_reg, byte_next;
    logic                cmd_reg, cmd_next;
    logic                err_reg, err_next;
    logic                last_reg, last_next;

    logic [OPND_W-1:0]   first_reg, first_next;
    logic [OPND_W-1:0]   second_reg, second_next;
    logic [1:0]          ndig_reg, ndig_next;
    logic                entsec_reg, entsec_next;
    logic [2:0]          op_reg, op_next;
    logic                fin_reg, fin_next;

    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                neg_reg, neg_next;
    logic [3:0]          dig_reg [4];
    logic [3:0]          dig_next [4];
    logic [2:0]          dcnt_reg, dcnt_next;

    div_req_t            dreq;
    div_rsp_t            drsp;

    logic                accept;
    logic [OPND_W-1:0]   cur_opnd;
    logic [9:0]          times_ten;
    logic [OPND_W-1:0]   entered;
    logic [OPND_W:0]     sum;
    logic [VALUE_W-1:0]  prod;
    logic [1:0]          didx;

    kfc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign accept    = in_valid && in_ready;
    assign cur_opnd  = entsec_reg ? second_reg : first_reg;
    assign times_ten = {cur_opnd, 3'b000} + {2'b00, cur_opnd, 1'b0};
    assign entered   = (ndig_reg == 2'd0) ? {3'b000, key_value}
                                          : times_ten[OPND_W-1:0] + {3'b000, key_value};
    assign sum       = {1'b0, first_reg} + {1'b0, second_reg};
    assign prod      = first_reg * second_reg;
    assign didx      = 2'(dcnt_reg - 3'd1);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        ov_next     = ov_reg;
        byte_next   = byte_reg;
        cmd_next    = cmd_reg;
        err_next    = err_reg;
        last_next   = last_reg;
        first_next  = first_reg;
        second_next = second_reg;
        ndig_next   = ndig_reg;
        entsec_next = entsec_reg;
        op_next     = op_reg;
        fin_next    = fin_reg;
        val_next    = val_reg;
        neg_next    = neg_reg;
        dig_next    = dig_reg;
        dcnt_next   = dcnt_reg;
        dreq        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_CLEAR)
                    begin
                        first_next  = '0;
                        second_next = '0;
                        ndig_next   = '0;
                        entsec_next = 1'b0;
                        op_next     = OP_NONE;
                        fin_next    = 1'b0;
                        {byte_next, cmd_next, err_next, last_next} = {CMD_CLEAR, 3'b101};
                        ov_next    = 1'b1;
                        ret_next   = S_IDLE;
                        state_next = S_OUT;
                    end
                    else if (!fin_reg)
                    begin
                        if (kind == KIND_DIGIT && key_value <= 4'd9)
                        begin
                            ov_next    = 1'b1;
                            ret_next   = S_IDLE;
                            state_next = S_OUT;
                            if (ndig_reg >= 2'd2)
                            begin
                                first_next  = '0;
                                second_next = '0;
                                ndig_next   = '0;
                                entsec_next = 1'b0;
                                op_next     = OP_NONE;
                                {byte_next, cmd_next, err_next, last_next} =
                                    {CMD_CLEAR, 3'b111};
                            end
                            else
                            begin
                                if (entsec_reg)
                                    second_next = entered;
                                else
                                    first_next = entered;
                                ndig_next = ndig_reg + 2'd1;
                                {byte_next, cmd_next, err_next, last_next} =
                                    {ASCII_ZERO + {4'b0000, key_value}, 3'b001};
                            end
                        end
                        else if (kind == KIND_OPER && key_value <= 4'd3 &&
                                 op_reg == OP_NONE && !entsec_reg && ndig_reg != 2'd0)
                        begin
                            op_next     = 3'(key_value) + 3'd1;
                            entsec_next = 1'b1;
                            ndig_next   = '0;
                            {byte_next, cmd_next, err_next, last_next} =
                                {op_glyph(key_value[1:0]), 3'b001};
                            ov_next    = 1'b1;
                            ret_next   = S_IDLE;
                            state_next = S_OUT;
                        end
                        else if (kind == KIND_EQUALS)
                        begin
                            {byte_next, cmd_next, err_next, last_next} =
                                {CMD_CURSOR, 3'b100};
                            ov_next    = 1'b1;
                            ret_next   = S_EQ;
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    ov_next    = 1'b0;
                    state_next = ret_reg;
                end
            end
            S_EQ:
            begin
                {byte_next, cmd_next, err_next, last_next} = {ASCII_EQUAL, 3'b000};
                ov_next    = 1'b1;
                ret_next   = (op_reg == OP_DIV && second_reg == '0) ? S_DZ : S_COMPUTE;
                state_next = S_OUT;
            end
            S_DZ:
            begin
                first_next  = '0;
                second_next = '0;
                ndig_next   = '0;
                entsec_next = 1'b0;
                op_next     = OP_NONE;
                {byte_next, cmd_next, err_next, last_next} = {CMD_CLEAR, 3'b111};
                ov_next    = 1'b1;
                ret_next   = S_IDLE;
                state_next = S_OUT;
            end
            S_COMPUTE:
            begin
                fin_next   = 1'b1;
                neg_next   = 1'b0;
                dcnt_next  = '0;
                state_next = S_SIGN;
                unique case (op_reg)
                    OP_ADD:  val_next = VALUE_W'(sum);
                    OP_SUB:
                    begin
                        if (first_reg >= second_reg)
                            val_next = VALUE_W'(first_reg - second_reg);
                        else
                        begin
                            val_next = VALUE_W'(second_reg - first_reg);
                            neg_next = 1'b1;
                        end
                    end
                    OP_MUL:  val_next = prod;
                    OP_DIV:
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = VALUE_W'(first_reg);
                        dreq.divisor  = second_reg;
                        state_next    = S_DIVW;
                    end
                    default: val_next = VALUE_W'(first_reg);
                endcase
            end
            S_DIVW:
            begin
                if (drsp.done)
                begin
                    val_next   = drsp.quotient;
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (neg_reg)
                begin
                    {byte_next, cmd_next, err_next, last_next} = {ASCII_MINUS, 3'b000};
                    ov_next    = 1'b1;
                    ret_next   = S_CONV;
                    state_next = S_OUT;
                end
                else
                    state_next = S_CONV;
            end
            S_CONV:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = val_reg;
                dreq.divisor  = RADIX;
                state_next    = S_CONVW;
            end
            S_CONVW:
            begin
                if (drsp.done)
                begin
                    dig_next[dcnt_reg[1:0]] = drsp.remainder[3:0];
                    dcnt_next = dcnt_reg + 3'd1;
                    val_next  = drsp.quotient;
                    state_next = (drsp.quotient == '0) ? S_DIGIT : S_CONV;
                end
            end
            S_DIGIT:
            begin
                {byte_next, cmd_next, err_next} = {ASCII_ZERO + {4'b0000, dig_reg[didx]}, 2'b00};
                last_next  = (dcnt_reg == 3'd1);
                dcnt_next  = dcnt_reg - 3'd1;
                ov_next    = 1'b1;
                ret_next   = (dcnt_reg == 3'd1) ? S_IDLE : S_DIGIT;
                state_next = S_OUT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            ov_reg     <= 1'b0;
            byte_reg   <= '0;
            cmd_reg    <= 1'b0;
            err_reg    <= 1'b0;
            last_reg   <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
            ndig_reg   <= '0;
            entsec_reg <= 1'b0;
            op_reg     <= OP_NONE;
            fin_reg    <= 1'b0;
            val_reg    <= '0;
            neg_reg    <= 1'b0;
            dig_reg    <= '{default: '0};
            dcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            ov_reg     <= ov_next;
            byte_reg   <= byte_next;
            cmd_reg    <= cmd_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            ndig_reg   <= ndig_next;
            entsec_reg <= entsec_next;
            op_reg     <= op_next;
            fin_reg    <= fin_next;
            val_reg    <= val_next;
            neg_reg    <= neg_next;
            dig_reg    <= dig_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = ov_reg;
    assign display_byte = byte_reg;
    assign is_command   = cmd_reg;
    assign is_error     = err_reg;
    assign last         = last_reg;

endmodule

>>> design/kfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfc_checker
// port-level checks on the keypad calculator, bound to the top level
// ----------------------------------------------------------------------------
module kfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] display_byte,
    input logic       is_command,
    input logic       is_error,
    input logic       last
);
    import kfc_pkg::*;

    // no new key while a beat is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while output beat pending");

    // clear key answers with a single clear command next cycle
    a_clear_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == KIND_CLEAR) |=>
        (out_valid && display_byte == CMD_CLEAR && is_command && last && !is_error))
        else $error("clear key did not give clear command");

    // more beats follow a beat without last
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> !in_ready)
        else $error("key ended on a beat without last");

    // error beats are final clear commands
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_error) |-> (display_byte == CMD_CLEAR && is_command && last))
        else $error("malformed error beat");

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(display_byte) && $stable(last)))
        else $error("output beat changed while stalled");

endmodule

bind keypad_four_function_calculator kfc_checker u_kfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .display_byte (display_byte),
    .is_command   (is_command),
    .is_error     (is_error),
    .last         (last)
);

>>> bench/keypad_four_function_calculator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_four_function_calculator_tb
// Self-checking bench for the keypad calculator. Key events go in through a
// valid/ready driver fed from a queue that is built up front: a short directed
// run over the corner cases, then random key sequences, mostly well formed
// with some noise mixed in. A behavioral calculator in the bench predicts the
// display beats of every accepted key. The monitor compares each output beat
// in order against those predictions. Both sides insert random gaps, and the
// receiver also holds off for a long stretch at set beat counts.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator_tb;

    import kfc_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_KEYS = 400;
    localparam int SETTLE_CYCLES = 150;
    localparam int LONG_HOLD = 250;

    localparam logic [3:0] KEY_ADD = 4'd0;
    localparam logic [3:0] KEY_SUB = 4'd1;
    localparam logic [3:0] KEY_MUL = 4'd2;
    localparam logic [3:0] KEY_DIV = 4'd3;

    typedef struct {
        logic [1:0] kind;
        logic [3:0] value;
        int         gap;
        bit         drain;
    } key_beat_t;

    typedef struct {
        logic [7:0] code;
        logic       is_cmd;
        logic       is_err;
        logic       is_last;
    } disp_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] kind = KIND_CLEAR;
    logic [3:0] key_value = 4'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] display_byte;
    logic       is_command;
    logic       is_error;
    logic       last;

    key_beat_t  key_q[$];
    disp_beat_t display_expected[$];
    disp_beat_t key_beats[$];
    key_beat_t  next_key;
    disp_beat_t want;

    logic [6:0] first_opnd;
    logic [6:0] second_opnd;
    logic [1:0] digit_cnt;
    logic       have_oper;
    logic [2:0] oper;
    logic       done_flag;

    int  fail_count = 0;
    int  idle_left = 0;
    int  stall_left = 0;
    int  calm_left = 0;
    int  beats_seen = 0;
    int  roll;
    bit  burst_mode = 1'b0;

    keypad_four_function_calculator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .key_value    (key_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .display_byte (display_byte),
        .is_command   (is_command),
        .is_error     (is_error),
        .last         (last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // calculator model

    task automatic calc_clear();
        first_opnd = '0;
        second_opnd = '0;
        digit_cnt = '0;
        have_oper = 1'b0;
        oper = OP_NONE;
        done_flag = 1'b0;
    endtask

    task automatic push_beat(input logic [7:0] code, input logic is_cmd, input logic is_err);
        disp_beat_t b;
        b.code = code;
        b.is_cmd = is_cmd;
        b.is_err = is_err;
        b.is_last = 1'b0;
        key_beats.push_back(b);
    endtask

    task automatic predict_display(input logic [1:0] k, input logic [3:0] v);
        int  x;
        int  y;
        int  th;
        int  hu;
        int  te;
        bit  neg;
        disp_beat_t b;
        key_beats.delete();
        neg = 1'b0;
        if (k == KIND_CLEAR)
        begin
            calc_clear();
            push_beat(CMD_CLEAR, 1'b1, 1'b0);
        end
        else if (done_flag)
        begin
        end
        else if (k == KIND_DIGIT)
        begin
            if (v > 4'd9)
            begin
            end
            else if (digit_cnt >= 2'd2)
            begin
                calc_clear();
                push_beat(CMD_CLEAR, 1'b1, 1'b1);
            end
            else
            begin
                if (have_oper)
                    second_opnd = (digit_cnt == 0) ? 7'(v) : 7'(int'(second_opnd) * 10 + int'(v));
                else
                    first_opnd = (digit_cnt == 0) ? 7'(v) : 7'(int'(first_opnd) * 10 + int'(v));
                digit_cnt = digit_cnt + 2'd1;
                push_beat(ASCII_ZERO + 8'(v), 1'b0, 1'b0);
            end
        end
        else if (k == KIND_OPER)
        begin
            if (v <= KEY_DIV && oper == OP_NONE && !have_oper && digit_cnt != 0)
            begin
                oper = 3'(v) + 3'd1;
                have_oper = 1'b1;
                digit_cnt = '0;
                case (v)
                    KEY_ADD: push_beat("+", 1'b0, 1'b0);
                    KEY_SUB: push_beat("-", 1'b0, 1'b0);
                    KEY_MUL: push_beat("x", 1'b0, 1'b0);
                    default: push_beat("/", 1'b0, 1'b0);
                endcase
            end
        end
        else
        begin
            x = int'(first_opnd);
            y = int'(second_opnd);
            push_beat(CMD_CURSOR, 1'b1, 1'b0);
            push_beat(ASCII_EQUAL, 1'b0, 1'b0);
            if (oper == OP_DIV && y == 0)
            begin
                calc_clear();
                push_beat(CMD_CLEAR, 1'b1, 1'b1);
            end
            else
            begin
                case (oper)
                    OP_ADD: x = x + y;
                    OP_SUB:
                    begin
                        if (x >= y)
                            x = x - y;
                        else
                        begin
                            x = y - x;
                            neg = 1'b1;
                        end
                    end
                    OP_MUL: x = x * y;
                    OP_DIV: x = x / y;
                    default: ;
                endcase
                if (neg)
                    push_beat(ASCII_MINUS, 1'b0, 1'b0);
                th = x / 1000;
                hu = (x % 1000) / 100;
                te = (x % 100) / 10;
                if (th != 0)
                    push_beat(ASCII_ZERO + 8'(th), 1'b0, 1'b0);
                if (th != 0 || hu != 0)
                    push_beat(ASCII_ZERO + 8'(hu), 1'b0, 1'b0);
                if (th != 0 || hu != 0 || te != 0)
                    push_beat(ASCII_ZERO + 8'(te), 1'b0, 1'b0);
                push_beat(ASCII_ZERO + 8'(x % 10), 1'b0, 1'b0);
                done_flag = 1'b1;
            end
        end
        for (int i = 0; i < key_beats.size(); i++)
        begin
            b = key_beats[i];
            b.is_last = (i == key_beats.size() - 1);
            display_expected.push_back(b);
        end
    endtask

    // stimulus building

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [3:0] pick_digit();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 4'd0;
        else if (r == 1)
            return 4'd9;
        else
            return 4'($urandom_range(0, 9));
    endfunction

    task automatic add_key(input logic [1:0] k, input logic [3:0] v, input bit drain);
        key_beat_t kb;
        kb.kind = k;
        kb.value = v;
        kb.gap = pick_gap();
        kb.drain = drain;
        key_q.push_back(kb);
    endtask

    task automatic add_random_sequence(input bit drain);
        int nd;
        add_key(KIND_CLEAR, 4'($urandom_range(0, 15)), drain);
        nd = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(1, 2);
        for (int i = 0; i < nd; i++)
            add_key(KIND_DIGIT, pick_digit(), 1'b0);
        add_key(KIND_OPER, 4'($urandom_range(0, 3)), 1'b0);
        nd = $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2);
        for (int i = 0; i < nd; i++)
            add_key(KIND_DIGIT, pick_digit(), 1'b0);
        add_key(KIND_EQUALS, 4'($urandom_range(0, 15)), 1'b0);
    endtask

    task automatic build_stimulus();
        int nseq;
        int n;
        add_key(KIND_CLEAR, 4'd0, 1'b0);
        add_key(KIND_OPER, KEY_ADD, 1'b0);
        add_key(KIND_DIGIT, 4'd15, 1'b0);
        add_key(KIND_EQUALS, 4'd0, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_OPER, KEY_MUL, 1'b0);
        add_key(KIND_EQUALS, 4'd0, 1'b0);
        add_key(KIND_CLEAR, 4'd15, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_OPER, 4'd15, 1'b0);
        add_key(KIND_OPER, KEY_ADD, 1'b0);
        add_key(KIND_OPER, KEY_MUL, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_DIGIT, 4'd7, 1'b0);
        add_key(KIND_DIGIT, 4'd0, 1'b0);
        add_key(KIND_OPER, KEY_SUB, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_EQUALS, 4'd0, 1'b0);
        add_key(KIND_CLEAR, 4'd0, 1'b0);
        add_key(KIND_DIGIT, 4'd5, 1'b0);
        add_key(KIND_OPER, KEY_DIV, 1'b0);
        add_key(KIND_EQUALS, 4'd0, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_OPER, KEY_MUL, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_DIGIT, 4'd9, 1'b0);
        add_key(KIND_EQUALS, 4'd0, 1'b0);
        nseq = 0;
        n = 0;
        while (n < RANDOM_KEYS)
        begin
            burst_mode = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                add_random_sequence(nseq == 0 || $urandom_range(0, 19) == 0);
                nseq++;
                n = key_q.size();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    add_key(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b0);
            end
        end
        burst_mode = 1'b0;
    endtask

    // key driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= KIND_CLEAR;
            key_value <= 4'd0;
            idle_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_display(kind, key_value);
            if (in_valid && !in_ready)
            begin
            end
            else if (idle_left != 0)
            begin
                idle_left <= idle_left - 1;
                in_valid <= 1'b0;
            end
            else if (key_q.size() != 0 && !(key_q[0].drain && display_expected.size() != 0))
            begin
                next_key = key_q.pop_front();
                in_valid <= 1'b1;
                kind <= next_key.kind;
                key_value <= next_key.value;
                idle_left <= next_key.gap;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // display monitor

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            calm_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                beats_seen <= beats_seen + 1;
                if (display_expected.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected beat expected none actual byte=%02h cmd=%0b err=%0b last=%0b",
                        $time, display_byte, is_command, is_error, last);
                end
                else
                begin
                    want = display_expected.pop_front();
                    if (display_byte !== want.code || is_command !== want.is_cmd ||
                        is_error !== want.is_err || last !== want.is_last)
                    begin
                        fail_count++;
                        $display("%0t: beat mismatch expected byte=%02h cmd=%0b err=%0b last=%0b",
                            $time, want.code, want.is_cmd, want.is_err, want.is_last);
                        $display("%0t: beat mismatch actual   byte=%02h cmd=%0b err=%0b last=%0b",
                            $time, display_byte, is_command, is_error, last);
                    end
                end
            end
            roll = $urandom_range(0, 99);
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready && (beats_seen == 40 || beats_seen == 600))
            begin
                stall_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (calm_left != 0)
            begin
                calm_left <= calm_left - 1;
                out_ready <= 1'b1;
            end
            else if (roll < 3)
            begin
                calm_left <= $urandom_range(50, 150);
                out_ready <= 1'b1;
            end
            else if (roll < 6)
            begin
                stall_left <= $urandom_range(20, 60);
                out_ready <= 1'b0;
            end
            else if (roll < 30)
            begin
                stall_left <= $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        calc_clear();
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        wait (key_q.size() == 0 && !in_valid);
        wait (display_expected.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && display_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(4_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
design/kfc_pkg.sv
design/kfc_divider.sv
design/keypad_four_function_calculator.sv
design/kfc_checker.sv
bench/keypad_four_function_calculator_tb.sv
